// ----- sv/pfe_pkg.sv -----
package pfe_pkg;

	// default sizes
	localparam int DEF_STACK_DEPTH = 16;
	localparam int DEF_VALUE_BITS  = 32;

	// fixed field widths
	localparam int SYM_BITS    = 8;
	localparam int OUT_BITS    = 32;
	localparam int STATUS_BITS = 3;

	typedef logic [STATUS_BITS-1:0] status_t;

	// sticky status codes
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_UNDERFLOW = 3'd1;
	localparam status_t ST_OVERFLOW  = 3'd2;
	localparam status_t ST_DIVZERO   = 3'd3;
	localparam status_t ST_ILLEGAL   = 3'd4;

	// ascii symbols
	localparam logic [SYM_BITS-1:0] CH_ZERO  = 8'd48;
	localparam logic [SYM_BITS-1:0] CH_NINE  = 8'd57;
	localparam logic [SYM_BITS-1:0] CH_PLUS  = 8'h2b;
	localparam logic [SYM_BITS-1:0] CH_MINUS = 8'h2d;
	localparam logic [SYM_BITS-1:0] CH_STAR  = 8'h2a;
	localparam logic [SYM_BITS-1:0] CH_SLASH = 8'h2f;

	// shared unit operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t OP_ADD = 2'd0;
	localparam alu_op_t OP_SUB = 2'd1;
	localparam alu_op_t OP_MUL = 2'd2;
	localparam alu_op_t OP_DIV = 2'd3;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

endpackage

// ----- sv/pfe_in_if.sv -----
interface pfe_in_if;
	import pfe_pkg::*;

	logic                valid;
	logic                ready;
	logic [SYM_BITS-1:0] symbol;
	logic                is_end;

	modport source (output valid, output symbol, output is_end, input ready);
	modport sink (input valid, input symbol, input is_end, output ready);

endinterface

// ----- sv/pfe_out_if.sv -----
interface pfe_out_if;
	import pfe_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] value;
	logic [STATUS_BITS-1:0]     status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);

endinterface

// ----- sv/pfe_alu.sv -----
module pfe_alu #(
	parameter int VALUE_BITS = pfe_pkg::DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfe_pkg::alu_ctl_t     ctl,
	input  logic [VALUE_BITS-1:0] a,
	input  logic [VALUE_BITS-1:0] b,
	output logic                  done,
	output logic [VALUE_BITS-1:0] result
);
	import pfe_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int SW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] steps_q;
	alu_op_t       op_q;
	logic          neg_q;
	logic [W-1:0]  x_q;    // multiplicand, or dividend shifting into quotient
	logic [W-1:0]  y_q;    // multiplier, or divisor magnitude
	logic [W-1:0]  rem_q;
	logic [W-1:0]  res_q;

	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;
	logic [W:0]   trial;
	logic [W:0]   diff;

	always_comb begin
		mag_a = a[W-1] ? (-a) : a;
		mag_b = b[W-1] ? (-b) : b;
		trial = {rem_q, x_q[W-1]};
		diff  = trial - {1'b0, y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				case (ctl.op)
					OP_ADD, OP_SUB: begin
						done_q <= 1'b1;
					end
					OP_MUL: begin
						busy_q  <= 1'b1;
						steps_q <= SW'(W);
					end
					OP_DIV: begin
						if (b == '0) begin
							done_q <= 1'b1;
						end else begin
							busy_q  <= 1'b1;
							steps_q <= SW'(W);
						end
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				if (steps_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					steps_q <= steps_q - 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q  <= ctl.op;
			neg_q <= a[W-1] ^ b[W-1];
			rem_q <= '0;
			case (ctl.op)
				OP_ADD: res_q <= a + b;
				OP_SUB: res_q <= a - b;
				OP_MUL: begin
					res_q <= '0;
					x_q   <= a;
					y_q   <= b;
				end
				OP_DIV: begin
					res_q <= '0;
					x_q   <= mag_a;
					y_q   <= mag_b;
				end
				default: res_q <= '0;
			endcase
		end else if (busy_q) begin
			if (steps_q == '0) begin
				// sign fix of the quotient
				if (op_q == OP_DIV) begin
					res_q <= neg_q ? (-x_q) : x_q;
				end
			end else if (op_q == OP_MUL) begin
				if (y_q[0]) begin
					res_q <= res_q + x_q;
				end
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end else begin
				// restoring division step
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					x_q   <= {x_q[W-2:0], 1'b1};
				end else begin
					rem_q <= trial[W-1:0];
					x_q   <= {x_q[W-2:0], 1'b0};
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- sv/postfix_expression_evaluator_unit.sv -----
// postfix (rpn) evaluator: one ascii character per item on expr; digits push,
// + - * / pop right then left and push left op right in VALUE_BITS two's
// complement with wrap, division truncating toward zero. an item with is_end
// set pops the top of stack onto result (value and the first error of the
// expression as status) and clears stack and status; other items give no
// result. the block takes one item at a time. + - * / are computed by the
// shared shift-add / restoring-divide unit, which works one bit per cycle
// for * and /, and a terminator waits until the result slot is free.
// the stack lives in a single-port-read memory, so the two operands are
// fetched in consecutive cycles. stack entries hold garbage until pushed.
module postfix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_BITS  = pfe_pkg::DEF_VALUE_BITS
) (
	input logic   clk,
	input logic   arst_n,
	pfe_in_if.sink    expr,
	pfe_out_if.source result
);
	import pfe_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
	localparam logic [2:0] S_DEC  = 3'd1;  // decode, push digit, fetch top
	localparam logic [2:0] S_RD2  = 3'd2;  // right operand in, fetch left
	localparam logic [2:0] S_OP   = 3'd3;  // left operand in, start unit
	localparam logic [2:0] S_WAIT = 3'd4;  // wait for unit, write back
	localparam logic [2:0] S_EMIT = 3'd5;  // hand result to output register

	logic [2:0]          state_q;
	logic [CW-1:0]       cnt_q;
	status_t             err_q;
	logic [SYM_BITS-1:0] sym_q;
	logic                end_q;
	alu_op_t             op_q;
	logic [W-1:0]        right_q;
	logic [W-1:0]        rd_q;

	// output register
	logic                out_valid_q;
	logic [OUT_BITS-1:0] value_q;
	status_t             status_q;

	// stack memory
	logic [W-1:0] stack_mem [STACK_DEPTH];
	logic          we;
	logic [AW-1:0] wa;
	logic [W-1:0]  wd;
	logic [AW-1:0] ra;

	// symbol decode
	logic    is_digit;
	logic    is_oper;
	alu_op_t sym_op;

	// shared unit
	alu_ctl_t     alu_ctl;
	logic         alu_done;
	logic [W-1:0] alu_res;

	always_comb begin
		is_digit = (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
		is_oper  = 1'b1;
		sym_op   = OP_ADD;
		case (sym_q)
			CH_PLUS:  sym_op = OP_ADD;
			CH_MINUS: sym_op = OP_SUB;
			CH_STAR:  sym_op = OP_MUL;
			CH_SLASH: sym_op = OP_DIV;
			default:  is_oper = 1'b0;
		endcase
	end

	// top of stack unless the left operand is wanted
	assign ra = (state_q == S_RD2) ? AW'(cnt_q - CW'(2)) : AW'(cnt_q - CW'(1));

	always_comb begin
		we = 1'b0;
		wa = AW'(cnt_q);
		wd = alu_res;
		if (state_q == S_DEC && !end_q && is_digit && cnt_q < CW'(STACK_DEPTH)) begin
			// digit value is the low nibble of its ascii code
			we = 1'b1;
			wd = W'(sym_q[3:0]);
		end else if (state_q == S_WAIT && alu_done) begin
			we = 1'b1;
			wa = AW'(cnt_q - CW'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stack_mem[wa] <= wd;
		end
		rd_q <= stack_mem[ra];
	end

	assign alu_ctl.start = (state_q == S_OP);
	assign alu_ctl.op    = op_q;

	pfe_alu #(
		.VALUE_BITS(VALUE_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (rd_q),
		.b      (right_q),
		.done   (alu_done),
		.result (alu_res)
	);

	assign expr.ready = (state_q == S_IDLE);

	// sequencer, stack count and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (expr.valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (end_q) begin
						if (cnt_q == '0 && err_q == ST_OK) begin
							err_q <= ST_UNDERFLOW;
						end
						state_q <= S_EMIT;
					end else if (is_digit) begin
						if (cnt_q < CW'(STACK_DEPTH)) begin
							cnt_q <= cnt_q + 1'b1;
						end else if (err_q == ST_OK) begin
							err_q <= ST_OVERFLOW;
						end
						state_q <= S_IDLE;
					end else if (is_oper) begin
						if (cnt_q < CW'(2)) begin
							if (err_q == ST_OK) begin
								err_q <= ST_UNDERFLOW;
							end
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD2;
						end
					end else begin
						if (err_q == ST_OK) begin
							err_q <= ST_ILLEGAL;
						end
						state_q <= S_IDLE;
					end
				end
				S_RD2: begin
					state_q <= S_OP;
				end
				S_OP: begin
					// division by zero still pushes the zero from the unit
					if (op_q == OP_DIV && right_q == '0 && err_q == ST_OK) begin
						err_q <= ST_DIVZERO;
					end
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_done) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					// slot free now or freed this cycle
					if (!out_valid_q || result.ready) begin
						cnt_q   <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// output slot: loaded on emit, freed by the handshake
			if (state_q == S_EMIT && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && expr.valid) begin
			sym_q <= expr.symbol;
			end_q <= expr.is_end;
		end
		if (state_q == S_DEC) begin
			op_q <= sym_op;
		end
		if (state_q == S_RD2) begin
			right_q <= rd_q;
		end
		if (state_q == S_EMIT && (!out_valid_q || result.ready)) begin
			value_q  <= (cnt_q == '0) ? '0 : OUT_BITS'(rd_q);
			status_q <= err_q;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.value  = value_q;
	assign result.status = status_q;

	// stack count never passes the depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// a new result only comes out of the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q ##1 out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

	// the shared unit only finishes while the sequencer waits for it
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_WAIT))
		else $error("unit done outside wait");

	// a delivered terminator leaves an empty stack and clean status
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !out_valid_q) |=> (cnt_q == '0 && err_q == ST_OK))
		else $error("stack not cleared after terminator");

endmodule
